@@ hw/rtl/ipe_pkg.sv @@
package ipe_pkg;

    // width of one part value and of the total
    localparam int PW = 5;
    // width of the position field
    localparam int PPW = 4;
    // largest total the enumerator handles
    localparam int MAX_VALUE = 16;

    // register index, taken from paddr[2]
    localparam logic REG_TOTAL_N = 1'b0;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_RESTART,
        DP_ADV_START,
        DP_SCAN,
        DP_DIST,
        DP_OUT_PART,
        DP_OUT_FIN
    } dp_op_t;

    typedef struct packed {
        logic len_zero;
        logic rd_le1;
        logic idx_zero;
        logic at_max;
        logic more;
        logic emit_last;
        logic slot_free;
    } dp_status_t;

endpackage

@@ hw/rtl/integer_partition_enumerator.sv @@
// restart request: stores the clamped total as the single part {n}, then emits it
// advance request: scans the trailing ones right to left, decrements the part before them,
// redistributes the sum, then emits each part in turn through the single-port part store
// one request at a time; the next is taken once the last result is in the output register
// synchronous active-low reset: empty store (next advance gives finished), total_n = 1
module integer_partition_enumerator import ipe_pkg::*; #(
    parameter int MAX_PARTS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_restart,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [PW-1:0]   m_part_value,
    output logic [PPW-1:0]  m_part_position,
    output logic            m_last_part,
    output logic            m_finished,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    logic [PW-1:0] total_n_reg;
    dp_status_t    status;
    dp_op_t        op;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_n_reg <= PW'(1);
        end else if (psel && penable && pwrite && (paddr[2] == REG_TOTAL_N)) begin
            total_n_reg <= pwdata[PW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_TOTAL_N) begin
            prdata = 32'(total_n_reg);
        end
    end

    ipe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_restart (s_restart),
        .s_ready   (s_ready),
        .status    (status),
        .op        (op)
    );

    ipe_dp #(
        .MAX_PARTS (MAX_PARTS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .op              (op),
        .total_n         (total_n_reg),
        .m_ready         (m_ready),
        .status          (status),
        .m_valid         (m_valid),
        .m_part_value    (m_part_value),
        .m_part_position (m_part_position),
        .m_last_part     (m_last_part),
        .m_finished      (m_finished)
    );

    // finished item is a lone zero entry closing its run
    a_fin_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_finished |-> m_last_part && (m_part_value == '0)
            && (m_part_position == '0))
        else $error("finished item malformed");

    // the store never holds a zero part inside the partition
    a_part_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_finished |-> (m_part_value != '0))
        else $error("zero part emitted");

    // every accepted request produces at least one result before the next is taken
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous still in work");

endmodule

@@ hw/rtl/ipe_dp.sv @@
module ipe_dp import ipe_pkg::*; #(
    parameter int MAX_PARTS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_op_t              op,
    input  logic [PW-1:0]       total_n,
    input  logic                m_ready,
    output dp_status_t          status,
    output logic                m_valid,
    output logic [PW-1:0]       m_part_value,
    output logic [PPW-1:0]      m_part_position,
    output logic                m_last_part,
    output logic                m_finished
);

    localparam int AW  = $clog2(MAX_PARTS);
    localparam int LW  = $clog2(MAX_PARTS + 1);
    localparam int CAP = (MAX_PARTS < MAX_VALUE) ? MAX_PARTS : MAX_VALUE;

    logic [PW-1:0] mem [MAX_PARTS];
    logic [PW-1:0] rdata_reg;

    logic [LW-1:0] idx_reg, idx_next;
    logic [LW-1:0] len_reg, len_next;
    logic [PW-1:0] sum_reg, sum_next;
    logic [PW-1:0] cur_reg, cur_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [PW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [PW-1:0] restart_n;

    logic           m_valid_reg, m_valid_next;
    logic [PW-1:0]  value_reg, value_next;
    logic [PPW-1:0] pos_reg, pos_next;
    logic           last_reg, last_next;
    logic           fin_reg, fin_next;

    // total clamped into the range the store can hold
    always_comb begin
        if (total_n == '0) begin
            restart_n = PW'(1);
        end else if (total_n > PW'(CAP)) begin
            restart_n = PW'(CAP);
        end else begin
            restart_n = total_n;
        end
    end

    assign rd_addr = (idx_reg < LW'(MAX_PARTS)) ? idx_reg[AW-1:0] : '0;

    assign status.len_zero  = (len_reg == '0);
    assign status.rd_le1    = (rdata_reg <= PW'(1));
    assign status.idx_zero  = (idx_reg == '0);
    assign status.at_max    = (idx_reg == LW'(MAX_PARTS));
    assign status.more      = (sum_reg > cur_reg);
    assign status.emit_last = ((idx_reg + LW'(1)) == len_reg);
    assign status.slot_free = !m_valid_reg || m_ready;

    always_comb begin
        idx_next     = idx_reg;
        len_next     = len_reg;
        sum_next     = sum_reg;
        cur_next     = cur_reg;
        wr_en        = 1'b0;
        wr_addr      = rd_addr;
        wr_data      = '0;
        m_valid_next = m_valid_reg && !m_ready;
        value_next   = value_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        fin_next     = fin_reg;
        case (op)
            DP_RESTART: begin
                wr_en    = 1'b1;
                wr_addr  = '0;
                wr_data  = restart_n;
                len_next = LW'(1);
                idx_next = '0;
            end
            DP_ADV_START: begin
                idx_next = len_reg - LW'(1);
                sum_next = '0;
            end
            DP_SCAN: begin
                sum_next = sum_reg + PW'(1);
                if (status.rd_le1) begin
                    // trailing one: absorb it and step left
                    if (status.idx_zero) begin
                        len_next = '0;
                    end else begin
                        idx_next = idx_reg - LW'(1);
                    end
                end else begin
                    wr_en    = 1'b1;
                    wr_data  = rdata_reg - PW'(1);
                    cur_next = rdata_reg - PW'(1);
                    idx_next = idx_reg + LW'(1);
                end
            end
            DP_DIST: begin
                if (status.at_max) begin
                    len_next = LW'(MAX_PARTS);
                    idx_next = '0;
                end else if (status.more) begin
                    wr_en    = 1'b1;
                    wr_data  = cur_reg;
                    sum_next = sum_reg - cur_reg;
                    idx_next = idx_reg + LW'(1);
                end else begin
                    wr_en    = 1'b1;
                    wr_data  = sum_reg;
                    len_next = idx_reg + LW'(1);
                    idx_next = '0;
                end
            end
            DP_OUT_PART: begin
                m_valid_next = 1'b1;
                value_next   = rdata_reg;
                pos_next     = PPW'(idx_reg);
                last_next    = status.emit_last;
                fin_next     = 1'b0;
                if (!status.emit_last) begin
                    idx_next = idx_reg + LW'(1);
                end
            end
            DP_OUT_FIN: begin
                m_valid_next = 1'b1;
                value_next   = '0;
                pos_next     = '0;
                last_next    = 1'b1;
                fin_next     = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg   <= idx_next;
        sum_reg   <= sum_next;
        cur_reg   <= cur_next;
        value_reg <= value_next;
        pos_reg   <= pos_next;
        last_reg  <= last_next;
        fin_reg   <= fin_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_part_value    = value_reg;
    assign m_part_position = pos_reg;
    assign m_last_part     = last_reg;
    assign m_finished      = fin_reg;

endmodule

@@ hw/rtl/ipe_ctrl.sv @@
module ipe_ctrl import ipe_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_restart,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_op_t     op
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DIST,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        op         = DP_NOP;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_restart) begin
                        op         = DP_RESTART;
                        state_next = ST_EMIT_RD;
                    end else begin
                        op         = DP_ADV_START;
                        state_next = status.len_zero ? ST_FIN : ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                op = DP_SCAN;
                if (!status.rd_le1) begin
                    state_next = ST_DIST;
                end else if (status.idx_zero) begin
                    // all ones passed: nothing left
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_DIST: begin
                op = DP_DIST;
                if (status.at_max || !status.more) begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT: begin
                if (status.slot_free) begin
                    op         = DP_OUT_PART;
                    state_next = status.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_FIN: begin
                if (status.slot_free) begin
                    op         = DP_OUT_FIN;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
